### hw/rtl/sonification_time_warp_tracker_top_assert.svh
// ----------------------------------------------------------------------------
// Tracker assertion macros
// Shared forms for the concurrent checks of the tracker top level.
// ----------------------------------------------------------------------------
`ifndef SONIFICATION_TIME_WARP_TRACKER_TOP_ASSERT_SVH
`define SONIFICATION_TIME_WARP_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define STWT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define STWT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/stwt_pkg.sv
// ----------------------------------------------------------------------------
// Tracker package
// Types, codes and constants shared by the tracker modules.
// ----------------------------------------------------------------------------
package stwt_pkg;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_DGO, S_DWAIT, S_SAGO, S_SAWAIT, S_SBGO, S_SBWAIT,
    S_EAGO, S_EAWAIT, S_EPGO, S_EPWAIT, S_DONE
  } state_t;

  // Row under evaluation
  typedef enum logic [1:0] {PH_CUR, PH_LAST, PH_PREV, PH_NEXT} phase_t;

  typedef enum logic [1:0] {
    REG_MODEL_LENGTH, REG_AMP_RATE, REG_PITCH_RATE, REG_WARMUP
  } reg_idx_t;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Handshake status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  localparam logic [8:0]  AMP_MAX   = 9'd511;
  localparam logic [12:0] PITCH_MAX = 13'd6000;
  localparam logic [12:0] PITCH_MIN = 13'd220;
  localparam logic [23:0] ARG_MAX   = 24'hFF_FFFF;
  localparam logic [31:0] EXP_BASE  = 32'hFFFF_0000;
  localparam int          EXP_STEPS = 24;

  typedef logic [EXP_STEPS-1:0][31:0] fact_tab_t;

  // Repeated squares of the base factor, exp(-2^i / 65536) in Q0.32
  function automatic fact_tab_t exp_table();
    fact_tab_t  t;
    logic [63:0] f;
    f = {32'd0, EXP_BASE};
    for (int i = 0; i < EXP_STEPS; i++) begin
      t[i] = f[31:0];
      f = (f * f) >> 32;
    end
    return t;
  endfunction

endpackage

### hw/rtl/stwt_rowmem.sv
// ----------------------------------------------------------------------------
// Reference row memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module stwt_rowmem #(
  parameter int DEPTH = 1024,
  parameter int DW    = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/stwt_dist.sv
// ----------------------------------------------------------------------------
// Squared distance unit
// Accumulate squared component differences, one component a cycle.
// ----------------------------------------------------------------------------
module stwt_dist
  import stwt_pkg::*;
#(
  parameter int CB = 16,
  parameter int MW = 17,
  parameter int SW = 36
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [7:0][CB-1:0]  q,
  input  logic [7:0][CB-1:0]  row,
  output unit_stat_t          stat,
  output logic [SW-1:0]       acc_a,
  output logic [SW-1:0]       acc_b
);

  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [2:0]    k_r, k_nxt;
  logic [SW-1:0] acc_a_r, acc_a_nxt, acc_b_r, acc_b_nxt;
  logic signed [CB:0] diff;
  logic [CB:0]   mag;
  logic [MW-1:0] mag_s;
  logic [2*MW-1:0] sq;

  always_comb begin
    diff  = $signed({q[k_r][CB-1], q[k_r]}) - $signed({row[k_r][CB-1], row[k_r]});
    mag   = diff[CB] ? (CB+1)'(-diff) : diff;
    mag_s = (33'(mag) > 33'h3FFF_FFFF) ? '1 : mag[MW-1:0];
    sq    = mag_s * mag_s;
  end

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    k_nxt     = k_r;
    acc_a_nxt = acc_a_r;
    acc_b_nxt = acc_b_r;
    if (start) begin
      busy_nxt  = 1'b1;
      k_nxt     = 3'd0;
      acc_a_nxt = '0;
      acc_b_nxt = '0;
    end else if (busy_r) begin
      if (!k_r[2]) begin
        acc_a_nxt = acc_a_r + SW'(sq);
      end else begin
        acc_b_nxt = acc_b_r + SW'(sq);
      end
      k_nxt = k_r + 3'd1;
      if (k_r == 3'd7) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      k_r    <= k_nxt;
    end
    acc_a_r <= acc_a_nxt;
    acc_b_r <= acc_b_nxt;
  end

  assign stat  = '{busy: busy_r, done: done_r};
  assign acc_a = acc_a_r;
  assign acc_b = acc_b_r;

endmodule

### hw/rtl/stwt_isqrt.sv
// ----------------------------------------------------------------------------
// Integer square root
// Restoring digit recurrence, one result bit a cycle.
// ----------------------------------------------------------------------------
module stwt_isqrt
  import stwt_pkg::*;
#(
  parameter int SW = 36
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SW-1:0]     value,
  output unit_stat_t        stat,
  output logic [SW/2-1:0]   root
);

  localparam int RW = SW / 2;
  localparam int CNTW = $clog2(RW + 1);

  logic            busy_r, busy_nxt, done_r, done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0]   val_r, val_nxt;
  logic [RW:0]     rem_r, rem_nxt;
  logic [RW-1:0]   root_r, root_nxt;
  logic [RW+2:0]   rem_cat, trial, rem_sub;

  always_comb begin
    rem_cat = {rem_r, val_r[SW-1:SW-2]};
    trial   = {1'b0, root_r, 2'b01};
    rem_sub = rem_cat - trial;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    val_nxt  = val_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      val_nxt  = value;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      val_nxt = {val_r[SW-3:0], 2'b00};
      if (rem_cat >= trial) begin
        rem_nxt  = rem_sub[RW:0];
        root_nxt = {root_r[RW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_cat[RW:0];
        root_nxt = {root_r[RW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(RW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    val_r  <= val_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign stat = '{busy: busy_r, done: done_r};
  assign root = root_r;

endmodule

### hw/rtl/stwt_exp.sv
// ----------------------------------------------------------------------------
// Negative exponential unit
// Scale the distance by the rate, then multiply in one factor a cycle.
// ----------------------------------------------------------------------------
module stwt_exp
  import stwt_pkg::*;
#(
  parameter int CB = 16,
  parameter int DW = 19
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dval,
  input  logic [23:0]   rate,
  output unit_stat_t    stat,
  output logic          one,
  output logic [31:0]   res
);

  localparam int        FRAC = CB - 2;
  localparam fact_tab_t FACT = exp_table();

  logic          busy_r, busy_nxt, done_r, done_nxt, one_r, one_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [DW+11:0] plo_r, plo_nxt, phi;
  logic [DW+23:0] full, shifted;
  logic [23:0]   arg_r, arg_nxt;
  logic [31:0]   res_r, res_nxt;
  logic [4:0]    step;
  logic [63:0]   prod;

  always_comb begin
    phi     = dval * rate[23:12];
    full    = {phi, 12'd0} + (DW+24)'(plo_r);
    shifted = full >> FRAC;
    step    = cnt_r - 5'd2;
    prod    = res_r * FACT[step];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    plo_nxt  = plo_r;
    arg_nxt  = arg_r;
    res_nxt  = res_r;
    one_nxt  = one_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      one_nxt  = 1'b1;
      res_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd0) begin
        plo_nxt = dval * rate[11:0];
      end else if (cnt_r == 5'd1) begin
        arg_nxt = (|shifted[DW+23:24]) ? ARG_MAX : shifted[23:0];
      end else begin
        if (arg_r[step]) begin
          one_nxt = 1'b0;
          res_nxt = one_r ? FACT[step] : prod[63:32];
        end
        if (step == 5'(EXP_STEPS - 1)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    plo_r <= plo_nxt;
    arg_r <= arg_nxt;
    res_r <= res_nxt;
    one_r <= one_nxt;
  end

  assign stat = '{busy: busy_r, done: done_r};
  assign one  = one_r;
  assign res  = res_r;

endmodule

### hw/rtl/sonification_time_warp_tracker_top.sv
// A load request is written in its accept cycle and gives no result. A sample
// request reads the current row, the last row and up to both neighbor rows,
// runs four square roots and two exponentials, and hands its result over once
// any result stall clears. No new request is taken before that hand-over. Reset
// is synchronous, active low: position 0, registers at defaults, rows undefined.
// ----------------------------------------------------------------------------
// Sonification time-warp tracker
// Compare sensor quaternions with a stored reference motion, derive amplitude
// and pitch, and step the reference position by a nearest-neighbor rule.
// ----------------------------------------------------------------------------
`include "sonification_time_warp_tracker_top_assert.svh"

module sonification_time_warp_tracker_top
  import stwt_pkg::*;
#(
  parameter int MODEL_DEPTH    = 1024,
  parameter int COMPONENT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_req_type,
  input  logic [9:0]                       in_row_index,
  input  logic signed [COMPONENT_BITS-1:0] in_first_x,
  input  logic signed [COMPONENT_BITS-1:0] in_first_y,
  input  logic signed [COMPONENT_BITS-1:0] in_first_z,
  input  logic signed [COMPONENT_BITS-1:0] in_first_w,
  input  logic signed [COMPONENT_BITS-1:0] in_second_x,
  input  logic signed [COMPONENT_BITS-1:0] in_second_y,
  input  logic signed [COMPONENT_BITS-1:0] in_second_z,
  input  logic signed [COMPONENT_BITS-1:0] in_second_w,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [8:0]                       out_amplitude,
  output logic [12:0]                      out_pitch,
  output logic [9:0]                       out_model_position,
  // register write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [1:0]                       cfg_index,
  input  logic [23:0]                      cfg_wdata
);

  localparam int CB = COMPONENT_BITS;
  localparam int AW = $clog2(MODEL_DEPTH);
  localparam int CW = (AW + 1 > 11) ? AW + 1 : 11;    // position arithmetic
  localparam int MW = (CB + 1 > 30) ? 30 : CB + 1;    // saturated difference
  localparam int SW = 2 * MW + 2;                     // sum of four squares
  localparam int RW = MW + 1;                         // root of that sum
  localparam int DW = MW + 2;                         // sum of two roots

  // Registers
  logic [10:0] model_length_r;
  logic [23:0] amp_rate_r, pitch_rate_r;
  logic [9:0]  warmup_r;

  // Control and datapath state
  state_t          state_r, state_nxt;
  phase_t          phase_r, phase_nxt;
  logic [AW-1:0]   pos_r;
  logic [7:0][CB-1:0] q_r;
  logic [SW:0]     d0_r;
  logic [DW-1:0]   err_r, dist_r;
  logic [1:0]      adv_r;
  logic [8:0]      amp_r;
  logic [12:0]     pit_r;
  logic            out_valid_r;
  logic [8:0]      out_amp_r;
  logic [12:0]     out_pit_r;
  logic [9:0]      out_pos_r;

  // Derived position terms
  logic [CW-1:0] len_c, last_c, pos_ext, nxt_pos, idx_ext;
  logic          warm, has_next, pos_nz, nearer, out_free;

  // Memory and unit wiring
  logic                  mem_wr_en, mem_rd_en;
  logic [AW-1:0]         mem_rd_addr;
  logic [8*CB-1:0]       mem_rd_data;
  logic [7:0][CB-1:0]    row;
  logic [7:0][CB-1:0]    q_in;
  logic                  d_start, sq_start, ex_start, ex_amp_sel;
  unit_stat_t            d_stat, sq_stat, ex_stat;
  logic [SW-1:0]         acc_a, acc_b, sq_value;
  logic [SW:0]           pair;
  logic [RW-1:0]         sq_root;
  logic [DW-1:0]         ex_dist;
  logic [23:0]           ex_rate;
  logic                  ex_one;
  logic [31:0]           ex_res;
  logic [40:0]           amp_prod;
  logic [44:0]           pit_prod;
  logic [12:0]           pit_raw;

  assign q_in = {in_second_w, in_second_z, in_second_y, in_second_x,
                 in_first_w, in_first_z, in_first_y, in_first_x};
  assign row  = mem_rd_data;

  // Clamp the length to 2..depth, then derive the last row and the tests
  always_comb begin
    len_c = CW'(model_length_r);
    if (len_c < CW'(2)) begin
      len_c = CW'(2);
    end else if (len_c > CW'(MODEL_DEPTH)) begin
      len_c = CW'(MODEL_DEPTH);
    end
    last_c   = len_c - CW'(1);
    pos_ext  = CW'(pos_r);
    warm     = pos_ext < CW'(warmup_r);
    has_next = (pos_ext + CW'(1)) < CW'(MODEL_DEPTH);
    pos_nz   = pos_r != '0;
    pair     = {1'b0, acc_a} + {1'b0, acc_b};
    nearer   = pair < d0_r;
    nxt_pos  = pos_ext + CW'(adv_r);
    if (nxt_pos >= last_c) begin
      nxt_pos = last_c - CW'(1);
    end
    idx_ext  = CW'(in_row_index);
    out_free = !out_valid_r || !out_stall;
  end

  // Next state: walk current row, last row, then neighbors after warm-up
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_req_type == REQ_SAMPLE) begin
          state_nxt = S_READ;
          phase_nxt = PH_CUR;
        end
      end
      S_READ:  state_nxt = S_DGO;
      S_DGO:   state_nxt = S_DWAIT;
      S_DWAIT: begin
        if (d_stat.done) begin
          unique case (phase_r)
            PH_CUR, PH_LAST: state_nxt = S_SAGO;
            PH_PREV: begin
              if (!nearer && has_next) begin
                state_nxt = S_READ;
                phase_nxt = PH_NEXT;
              end else begin
                state_nxt = S_EAGO;
              end
            end
            PH_NEXT: state_nxt = S_EAGO;
            default: state_nxt = S_EAGO;
          endcase
        end
      end
      S_SAGO:   state_nxt = S_SAWAIT;
      S_SAWAIT: if (sq_stat.done) state_nxt = S_SBGO;
      S_SBGO:   state_nxt = S_SBWAIT;
      S_SBWAIT: begin
        if (sq_stat.done) begin
          priority if (phase_r == PH_CUR) begin
            state_nxt = S_READ;
            phase_nxt = PH_LAST;
          end else if (!warm && pos_nz) begin
            state_nxt = S_READ;
            phase_nxt = PH_PREV;
          end else if (!warm && has_next) begin
            state_nxt = S_READ;
            phase_nxt = PH_NEXT;
          end else begin
            state_nxt = S_EAGO;
          end
        end
      end
      S_EAGO:   state_nxt = S_EAWAIT;
      S_EAWAIT: if (ex_stat.done) state_nxt = S_EPGO;
      S_EPGO:   state_nxt = S_EPWAIT;
      S_EPWAIT: if (ex_stat.done) state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control outputs; hold the exp operands for the whole amplitude run
  always_comb begin
    in_stall    = state_r != S_IDLE;
    mem_wr_en   = (state_r == S_IDLE) && in_valid && (in_req_type == REQ_LOAD)
                  && (idx_ext < CW'(MODEL_DEPTH));
    mem_rd_en   = state_r == S_READ;
    d_start     = state_r == S_DGO;
    sq_start    = (state_r == S_SAGO) || (state_r == S_SBGO);
    ex_start    = (state_r == S_EAGO) || (state_r == S_EPGO);
    ex_amp_sel  = (state_r == S_EAGO) || (state_r == S_EAWAIT);
    sq_value    = (state_r == S_SAGO) ? acc_a : acc_b;
    ex_dist     = ex_amp_sel ? err_r : dist_r;
    ex_rate     = ex_amp_sel ? amp_rate_r : pitch_rate_r;
    unique case (phase_r)
      PH_CUR:  mem_rd_addr = pos_r;
      PH_LAST: mem_rd_addr = last_c[AW-1:0];
      PH_PREV: mem_rd_addr = pos_r - AW'(1);
      PH_NEXT: mem_rd_addr = pos_r + AW'(1);
      default: mem_rd_addr = pos_r;
    endcase
  end

  // Scale the exponentials to amplitude and pitch
  always_comb begin
    amp_prod = AMP_MAX * ex_res;
    pit_prod = PITCH_MAX * ex_res;
    pit_raw  = ex_one ? PITCH_MAX : pit_prod[44:32];
  end

  // Register writes; the port is always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      model_length_r <= 11'd1024;
      amp_rate_r     <= 24'd65536;
      pitch_rate_r   <= 24'd65536;
      warmup_r       <= 10'd100;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MODEL_LENGTH: model_length_r <= cfg_wdata[10:0];
        REG_AMP_RATE:     amp_rate_r     <= cfg_wdata;
        REG_PITCH_RATE:   pitch_rate_r   <= cfg_wdata;
        REG_WARMUP:       warmup_r       <= cfg_wdata[9:0];
        default:          model_length_r <= model_length_r;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_CUR;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (state_r == S_DONE && out_free) begin
        // hand over the result and advance the position
        out_valid_r <= 1'b1;
        pos_r       <= nxt_pos[AW-1:0];
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      q_r    <= q_in;
      adv_r  <= 2'd1;
      err_r  <= '0;
      dist_r <= '0;
    end
    if (state_r == S_DWAIT && d_stat.done) begin
      if (phase_r == PH_CUR) begin
        d0_r <= pair;
      end else if (phase_r == PH_PREV && nearer) begin
        adv_r <= 2'd0;   // hold: previous row is nearer
      end else if (phase_r == PH_NEXT && nearer) begin
        adv_r <= 2'd2;   // skip: next row is nearer
      end
    end
    if ((state_r == S_SAWAIT || state_r == S_SBWAIT) && sq_stat.done) begin
      if (phase_r == PH_CUR) begin
        err_r <= err_r + DW'(sq_root);
      end else begin
        dist_r <= dist_r + DW'(sq_root);
      end
    end
    if (state_r == S_EAWAIT && ex_stat.done) begin
      amp_r <= ex_one ? AMP_MAX : amp_prod[40:32];
    end
    if (state_r == S_EPWAIT && ex_stat.done) begin
      pit_r <= (pit_raw < PITCH_MIN) ? PITCH_MIN : pit_raw;
    end
    if (state_r == S_DONE && out_free) begin
      out_amp_r <= amp_r;
      out_pit_r <= pit_r;
      out_pos_r <= pos_ext[9:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_amplitude      = out_amp_r;
  assign out_pitch          = out_pit_r;
  assign out_model_position = out_pos_r;

  stwt_rowmem #(
    .DEPTH (MODEL_DEPTH),
    .DW    (8 * CB)
  ) u_rowmem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (idx_ext[AW-1:0]),
    .wr_data (q_in),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  stwt_dist #(
    .CB (CB),
    .MW (MW),
    .SW (SW)
  ) u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .start (d_start),
    .q     (q_r),
    .row   (row),
    .stat  (d_stat),
    .acc_a (acc_a),
    .acc_b (acc_b)
  );

  stwt_isqrt #(
    .SW (SW)
  ) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (sq_value),
    .stat  (sq_stat),
    .root  (sq_root)
  );

  stwt_exp #(
    .CB (CB),
    .DW (DW)
  ) u_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ex_start),
    .dval  (ex_dist),
    .rate  (ex_rate),
    .stat  (ex_stat),
    .one   (ex_one),
    .res   (ex_res)
  );

  // Input is held off for the whole of a sample request
  `STWT_ASSERT_IMP(a_busy_stall, state_r != S_IDLE, in_stall, "request taken while busy")
  // The root and exp units never run at the same time
  `STWT_ASSERT_IMP(a_one_unit, sq_stat.busy, !ex_stat.busy, "root and exp overlap")
  // Leaving the done state always presents a result
  `STWT_ASSERT_NXT(a_result_issue, state_r == S_DONE && out_free, out_valid_r,
                   "result not issued")

endmodule
